// ----- design/gbi_pkg.sv -----
// ----------------------------------------------------------------------------
// gbi_pkg: shared types and constants
// Field widths, grid geometry, table entry and cell-location types for the
// grid bilinear interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int COORD_W    = 16;
  localparam int STEP_W     = 16;
  localparam int PTS_W      = 6;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int VALUE_W    = 24;
  localparam int MAX_ROWS   = 1 << ROW_W;
  localparam int MAX_COLS   = 1 << COL_W;

  localparam int DIFF_W     = COORD_W + 1;
  localparam int T_W        = COORD_W + STEP_W;
  localparam int FRAC_SHIFT = 20;
  localparam int IPART_W    = T_W - FRAC_SHIFT;
  localparam int FRAC_LSB   = 8;
  localparam int FRAC_W     = 13;
  localparam int FRAC_ONE   = 1 << (FRAC_W - 1);
  localparam int WGT_W      = 2 * (FRAC_W - 1) + 1;
  localparam int PROD_W     = VALUE_W + WGT_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int RND_SHIFT  = 2 * (FRAC_W - 1);
  localparam int Q_W        = SUM_W - RND_SHIFT;

  localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1);
  localparam int NUM_BANKS  = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'sd1 <<< (RND_SHIFT - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_LOWER       = 3'd0,
    CFG_BETA_LOWER    = 3'd1,
    CFG_C_INV_STEP    = 3'd2,
    CFG_BETA_INV_STEP = 3'd3,
    CFG_C_POINTS      = 3'd4,
    CFG_BETA_POINTS   = 3'd5
  } cfg_idx_t;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t dtheta;
    value_t dy;
    value_t dx;
  } entry_t;

  typedef struct packed {
    logic [ROW_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
    logic              clamp;
  } loc_t;

endpackage

// ----- design/gbi_if.sv -----
// ----------------------------------------------------------------------------
// gbi_if: channel interfaces
// Input channel (write or query word) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface gbi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [gbi_pkg::COORD_W-1:0]     c_value;
  logic signed [gbi_pkg::COORD_W-1:0]     beta_value;
  logic [gbi_pkg::ROW_W-1:0]              row_index;
  logic [gbi_pkg::COL_W-1:0]              col_index;
  logic signed [gbi_pkg::VALUE_W-1:0]     write_dx;
  logic signed [gbi_pkg::VALUE_W-1:0]     write_dy;
  logic signed [gbi_pkg::VALUE_W-1:0]     write_dtheta;

  modport source (
    output valid, cmd, c_value, beta_value, row_index, col_index,
           write_dx, write_dy, write_dtheta,
    input  ready
  );
  modport sink (
    input  valid, cmd, c_value, beta_value, row_index, col_index,
           write_dx, write_dy, write_dtheta,
    output ready
  );
endinterface

interface gbi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gbi_pkg::VALUE_W-1:0] out_dx;
  logic signed [gbi_pkg::VALUE_W-1:0] out_dy;
  logic signed [gbi_pkg::VALUE_W-1:0] out_dtheta;
  logic                               clamped;

  modport source (output valid, out_dx, out_dy, out_dtheta, clamped, input ready);
  modport sink   (input  valid, out_dx, out_dy, out_dtheta, clamped, output ready);
endinterface

// ----- design/gbi_ram.sv -----
// ----------------------------------------------------------------------------
// gbi_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbi_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 72
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/gbi_locate.sv -----
// ----------------------------------------------------------------------------
// gbi_locate: coordinate to cell index and fraction
// Three stages: offset subtract, reciprocal-step multiply, index/fraction
// extraction with clamping to the grid.
// ----------------------------------------------------------------------------
module gbi_locate (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [gbi_pkg::COORD_W-1:0] value,
  input  logic signed [gbi_pkg::COORD_W-1:0] lower,
  input  logic [gbi_pkg::STEP_W-1:0]         inv_step,
  input  logic [gbi_pkg::ROW_W-1:0]          last_pt,
  output gbi_pkg::loc_t                      loc
);

  logic signed [gbi_pkg::DIFF_W-1:0]  diff_r, diff_nxt;
  logic                               neg_r;
  logic [gbi_pkg::T_W-1:0]            t_r, t_nxt;
  gbi_pkg::loc_t                      loc_r, loc_nxt;
  logic [gbi_pkg::IPART_W-1:0]        ipart;
  logic [gbi_pkg::IPART_W-1:0]        last_ext;

  assign diff_nxt = gbi_pkg::DIFF_W'(value) - gbi_pkg::DIFF_W'(lower);
  assign t_nxt    = gbi_pkg::T_W'(diff_r[gbi_pkg::COORD_W-1:0]) * gbi_pkg::T_W'(inv_step);
  assign ipart    = t_r[gbi_pkg::T_W-1:gbi_pkg::FRAC_SHIFT];
  assign last_ext = gbi_pkg::IPART_W'(last_pt);

  always_comb begin
    if (neg_r) begin
      loc_nxt.idx   = '0;
      loc_nxt.frac  = '0;
      loc_nxt.clamp = 1'b1;
    end else if (ipart >= last_ext) begin
      loc_nxt.idx   = last_pt - gbi_pkg::ROW_W'(1);
      loc_nxt.frac  = gbi_pkg::FRAC_W'(gbi_pkg::FRAC_ONE);
      loc_nxt.clamp = !((ipart == last_ext) && (t_r[gbi_pkg::FRAC_SHIFT-1:0] == '0));
    end else begin
      loc_nxt.idx   = ipart[gbi_pkg::ROW_W-1:0];
      loc_nxt.frac  = {1'b0, t_r[gbi_pkg::FRAC_SHIFT-1:gbi_pkg::FRAC_LSB]};
      loc_nxt.clamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      neg_r  <= diff_r[gbi_pkg::DIFF_W-1];
      t_r    <= t_nxt;
      loc_r  <= loc_nxt;
    end
  end

  assign loc = loc_r;

endmodule

// ----- design/grid_bilinear_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_top: bilinear lookup over a 32x32 vector grid
// Write words load table entries; query words return the blended
// (dx, dy, dtheta) of the four surrounding grid points.
// ----------------------------------------------------------------------------
// Takes one word per cycle, write or query, while the pipeline is not held,
// in a seven-stage pipeline ending in the output register. The whole pipeline
// holds while a result waits at the output and out_ch.ready is low, so
// in_ch.ready follows out_ch.ready whenever the output register is full.
// Writes and queries hit the table at the same stage, so a query sees every
// write accepted before it. The table sits in four RAM banks split by row
// and column parity, so the four corners of a cell are read in the same cycle.
// Table contents are undefined after reset until written; there is no
// clearing pass. Configuration is to be changed only when the block is idle.
module grid_bilinear_interpolator_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  gbi_in_if.sink                               in_ch,
  gbi_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbi_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // configuration
  logic signed [gbi_pkg::COORD_W-1:0] c_lower_r, beta_lower_r;
  logic [gbi_pkg::STEP_W-1:0]         c_inv_r, beta_inv_r;
  logic [gbi_pkg::PTS_W-1:0]          c_pts_r, beta_pts_r;
  logic [gbi_pkg::ROW_W-1:0]          c_last, beta_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_lower_r    <= '0;
      beta_lower_r <= -gbi_pkg::COORD_W'(6434);
      c_inv_r      <= gbi_pkg::STEP_W'(256);
      beta_inv_r   <= gbi_pkg::STEP_W'(256);
      c_pts_r      <= gbi_pkg::PTS_W'(gbi_pkg::MAX_ROWS);
      beta_pts_r   <= gbi_pkg::PTS_W'(gbi_pkg::MAX_COLS);
    end else if (cfg_we) begin
      unique case (gbi_pkg::cfg_idx_t'(cfg_index))
        gbi_pkg::CFG_C_LOWER:       c_lower_r    <= cfg_wdata;
        gbi_pkg::CFG_BETA_LOWER:    beta_lower_r <= cfg_wdata;
        gbi_pkg::CFG_C_INV_STEP:    c_inv_r      <= cfg_wdata;
        gbi_pkg::CFG_BETA_INV_STEP: beta_inv_r   <= cfg_wdata;
        gbi_pkg::CFG_C_POINTS:      c_pts_r      <= cfg_wdata[gbi_pkg::PTS_W-1:0];
        gbi_pkg::CFG_BETA_POINTS:   beta_pts_r   <= cfg_wdata[gbi_pkg::PTS_W-1:0];
        default: ;
      endcase
    end
  end

  // last grid point index, point count limited to 2..max
  always_comb begin
    if (c_pts_r < gbi_pkg::PTS_W'(2)) begin
      c_last = gbi_pkg::ROW_W'(1);
    end else if (c_pts_r > gbi_pkg::PTS_W'(gbi_pkg::MAX_ROWS)) begin
      c_last = gbi_pkg::ROW_W'(gbi_pkg::MAX_ROWS - 1);
    end else begin
      c_last = gbi_pkg::ROW_W'(c_pts_r - gbi_pkg::PTS_W'(1));
    end
    if (beta_pts_r < gbi_pkg::PTS_W'(2)) begin
      beta_last = gbi_pkg::ROW_W'(1);
    end else if (beta_pts_r > gbi_pkg::PTS_W'(gbi_pkg::MAX_COLS)) begin
      beta_last = gbi_pkg::ROW_W'(gbi_pkg::MAX_COLS - 1);
    end else begin
      beta_last = gbi_pkg::ROW_W'(beta_pts_r - gbi_pkg::PTS_W'(1));
    end
  end

  // pipeline control
  logic adv;
  logic out_valid_r;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic s1_q_r, s2_q_r, s3_q_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_ch.valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r && s3_q_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      out_valid_r <= s6_v_r;
    end
  end

  // write word carried to the table stage
  logic [gbi_pkg::ROW_W-1:0] s1_row_r, s2_row_r, s3_row_r;
  logic [gbi_pkg::COL_W-1:0] s1_col_r, s2_col_r, s3_col_r;
  gbi_pkg::entry_t           s1_ent_r, s2_ent_r, s3_ent_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q_r          <= in_ch.cmd;
      s1_row_r        <= in_ch.row_index;
      s1_col_r        <= in_ch.col_index;
      s1_ent_r.dx     <= in_ch.write_dx;
      s1_ent_r.dy     <= in_ch.write_dy;
      s1_ent_r.dtheta <= in_ch.write_dtheta;
      s2_q_r          <= s1_q_r;
      s2_row_r        <= s1_row_r;
      s2_col_r        <= s1_col_r;
      s2_ent_r        <= s1_ent_r;
      s3_q_r          <= s2_q_r;
      s3_row_r        <= s2_row_r;
      s3_col_r        <= s2_col_r;
      s3_ent_r        <= s2_ent_r;
    end
  end

  // locate both coordinates (stages 1..3)
  gbi_pkg::loc_t loc_c, loc_b;

  gbi_locate u_loc_c (
    .clk      (clk),
    .en       (adv),
    .value    (in_ch.c_value),
    .lower    (c_lower_r),
    .inv_step (c_inv_r),
    .last_pt  (c_last),
    .loc      (loc_c)
  );

  gbi_locate u_loc_b (
    .clk      (clk),
    .en       (adv),
    .value    (in_ch.beta_value),
    .lower    (beta_lower_r),
    .inv_step (beta_inv_r),
    .last_pt  (beta_last),
    .loc      (loc_b)
  );

  // table banks, indexed {row parity, col parity}
  logic [gbi_pkg::BANK_AW-1:0]    rd_addr [gbi_pkg::NUM_BANKS];
  gbi_pkg::entry_t                rd_data [gbi_pkg::NUM_BANKS];
  logic [1:0]                     wr_bank;
  logic [gbi_pkg::BANK_AW-1:0]    wr_addr;

  assign wr_bank = {s3_row_r[0], s3_col_r[0]};
  assign wr_addr = {s3_row_r[gbi_pkg::ROW_W-1:1], s3_col_r[gbi_pkg::COL_W-1:1]};

  for (genvar b = 0; b < gbi_pkg::NUM_BANKS; b++) begin : g_bank
    logic [gbi_pkg::ROW_W-1:0] row;
    logic [gbi_pkg::COL_W-1:0] col;

    assign row = (loc_c.idx[0] == b[1]) ? loc_c.idx : loc_c.idx + gbi_pkg::ROW_W'(1);
    assign col = (loc_b.idx[0] == b[0]) ? loc_b.idx : loc_b.idx + gbi_pkg::COL_W'(1);
    assign rd_addr[b] = {row[gbi_pkg::ROW_W-1:1], col[gbi_pkg::COL_W-1:1]};

    gbi_ram #(
      .ADDR_W (gbi_pkg::BANK_AW),
      .DATA_W ($bits(gbi_pkg::entry_t))
    ) u_ram (
      .clk   (clk),
      .we    (adv && s3_v_r && !s3_q_r && (wr_bank == 2'(b))),
      .waddr (wr_addr),
      .wdata (s3_ent_r),
      .re    (adv),
      .raddr (rd_addr[b]),
      .rdata (rd_data[b])
    );
  end

  // stage 4: weights alongside the table read
  logic [gbi_pkg::FRAC_W-1:0]   fc_inv, fb_inv;
  logic [gbi_pkg::WGT_W-1:0]    w11_r, w21_r, w12_r, w22_r;
  logic                         s4_ci0_r, s4_bi0_r, s4_clamp_r;

  assign fc_inv = gbi_pkg::FRAC_W'(gbi_pkg::FRAC_ONE) - loc_c.frac;
  assign fb_inv = gbi_pkg::FRAC_W'(gbi_pkg::FRAC_ONE) - loc_b.frac;

  always_ff @(posedge clk) begin
    if (adv) begin
      w11_r      <= gbi_pkg::WGT_W'(fc_inv * fb_inv);
      w21_r      <= gbi_pkg::WGT_W'(loc_c.frac * fb_inv);
      w12_r      <= gbi_pkg::WGT_W'(fc_inv * loc_b.frac);
      w22_r      <= gbi_pkg::WGT_W'(loc_c.frac * loc_b.frac);
      s4_ci0_r   <= loc_c.idx[0];
      s4_bi0_r   <= loc_b.idx[0];
      s4_clamp_r <= loc_c.clamp || loc_b.clamp;
    end
  end

  // stage 5: corner times weight, per channel
  gbi_pkg::entry_t v11, v21, v12, v22;

  assign v11 = rd_data[{ s4_ci0_r,  s4_bi0_r}];
  assign v21 = rd_data[{~s4_ci0_r,  s4_bi0_r}];
  assign v12 = rd_data[{ s4_ci0_r, ~s4_bi0_r}];
  assign v22 = rd_data[{~s4_ci0_r, ~s4_bi0_r}];

  logic signed [gbi_pkg::PROD_W-1:0] p11_r [3];
  logic signed [gbi_pkg::PROD_W-1:0] p21_r [3];
  logic signed [gbi_pkg::PROD_W-1:0] p12_r [3];
  logic signed [gbi_pkg::PROD_W-1:0] p22_r [3];
  logic                              s5_clamp_r;
  gbi_pkg::value_t                   c11 [3];
  gbi_pkg::value_t                   c21 [3];
  gbi_pkg::value_t                   c12 [3];
  gbi_pkg::value_t                   c22 [3];

  assign c11 = '{v11.dx, v11.dy, v11.dtheta};
  assign c21 = '{v21.dx, v21.dy, v21.dtheta};
  assign c12 = '{v12.dx, v12.dy, v12.dtheta};
  assign c22 = '{v22.dx, v22.dy, v22.dtheta};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p11_r[k] <= gbi_pkg::PROD_W'(c11[k] * $signed({1'b0, w11_r}));
        p21_r[k] <= gbi_pkg::PROD_W'(c21[k] * $signed({1'b0, w21_r}));
        p12_r[k] <= gbi_pkg::PROD_W'(c12[k] * $signed({1'b0, w12_r}));
        p22_r[k] <= gbi_pkg::PROD_W'(c22[k] * $signed({1'b0, w22_r}));
      end
      s5_clamp_r <= s4_clamp_r;
    end
  end

  // stage 6: pair sums
  logic signed [gbi_pkg::SUM_W-1:0] sa_r [3];
  logic signed [gbi_pkg::SUM_W-1:0] sb_r [3];
  logic                             s6_clamp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sa_r[k] <= gbi_pkg::SUM_W'(p11_r[k]) + gbi_pkg::SUM_W'(p21_r[k]);
        sb_r[k] <= gbi_pkg::SUM_W'(p12_r[k]) + gbi_pkg::SUM_W'(p22_r[k]);
      end
      s6_clamp_r <= s5_clamp_r;
    end
  end

  // stage 7: round, scale, saturate
  logic signed [gbi_pkg::SUM_W-1:0] tot [3];
  logic signed [gbi_pkg::Q_W-1:0]   qv  [3];
  gbi_pkg::value_t                  res [3];
  gbi_pkg::value_t                  out_r [3];
  logic                             out_clamp_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot[k] = sa_r[k] + sb_r[k] + gbi_pkg::RND_HALF;
      qv[k]  = tot[k][gbi_pkg::SUM_W-1:gbi_pkg::RND_SHIFT];
      if (qv[k] > gbi_pkg::Q_MAX) begin
        res[k] = gbi_pkg::VALUE_W'(gbi_pkg::Q_MAX);
      end else if (qv[k] < gbi_pkg::Q_MIN) begin
        res[k] = gbi_pkg::VALUE_W'(gbi_pkg::Q_MIN);
      end else begin
        res[k] = qv[k][gbi_pkg::VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r       <= res;
      out_clamp_r <= s6_clamp_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_dx     = out_r[0];
  assign out_ch.out_dy     = out_r[1];
  assign out_ch.out_dtheta = out_r[2];
  assign out_ch.clamped    = out_clamp_r;

endmodule
